@@ rtl/hsv2rgb_pkg.sv @@
// Shared types for the HSV to RGB converter.
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  typedef enum logic [2:0] {
    SEC_0,
    SEC_1,
    SEC_2,
    SEC_3,
    SEC_4,
    SEC_5
  } sector_t;

  localparam int NUM_STAGES = 4;

endpackage

@@ rtl/hsv2rgb_if.sv @@
// Valid/ready channel interfaces for the HSV input and RGB output items.
`timescale 1ns / 1ps

interface hsv2rgb_in_if #(
  parameter int W = 17
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] hue;
  logic [W-1:0] saturation;
  logic [W-1:0] brightness;

  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv2rgb_out_if #(
  parameter int W = 17
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] red_out;
  logic [W-1:0] green_out;
  logic [W-1:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

@@ rtl/hsv2rgb_fxmul.sv @@
// Registered fixed-point multiplier that keeps a shifted slice of the product.
`timescale 1ns / 1ps

module hsv2rgb_fxmul #(
  parameter int AW    = 17,
  parameter int BW    = 17,
  parameter int OW    = 17,
  parameter int SHIFT = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [AW-1:0] a,
  input  logic [BW-1:0] b,
  output logic [OW-1:0] y
);

  localparam int PW = AW + BW;

  logic [PW-1:0] prod;

  assign prod = PW'(a) * PW'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      y <= prod[SHIFT +: OW];
    end
  end

endmodule

@@ rtl/hsv_to_rgb_converter_core.sv @@
// Top level of the pipelined HSV to RGB pixel converter.
`timescale 1ns / 1ps

// The block converts one pixel per item from hue, saturation and value to
// red, green and blue. All fields are unsigned fractions with FRAC_BITS
// fractional bits, where a value of one is 2^FRAC_BITS; inputs above one are
// saturated to one, and a hue of exactly one is treated as hue zero.
// The input item arrives on pixel_in and the result item leaves on pixel_out,
// both valid/ready channels; an item moves when valid and ready are high at a
// rising clock edge.
// The pipeline has four register stages: clamp and sector split, the three
// first products, the two second products, and the sector select into the
// output register. A result is offered once its item reaches the output
// register, and one item is taken in every cycle while results are drained.
// Each stage has its own valid bit and moves forward when the next stage is
// empty or moving, so bubbles are squeezed out when the receiver stalls and
// no item is lost or repeated. Synchronous reset clears all valid bits; the
// data registers are not reset.
module hsv_to_rgb_converter_core #(
  parameter int FRAC_BITS = 16
) (
  input logic             clk,
  input logic             rst,
  hsv2rgb_in_if.sink      pixel_in,
  hsv2rgb_out_if.source   pixel_out
);

  import hsv2rgb_pkg::*;

  localparam int W = FRAC_BITS + 1;
  localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] adv;

  always_comb begin
    adv[NUM_STAGES-1] = !vld[NUM_STAGES-1] || pixel_out.ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign pixel_in.ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= pixel_in.valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Stage 0: saturate inputs and split hue times six.
  logic [W-1:0]           h_cl;
  logic [W-1:0]           s_cl;
  logic [W-1:0]           v_cl;
  logic [W+1:0]           h6;
  sector_t                sec_next;
  sector_t                s0_sec;
  logic [FRAC_BITS-1:0]   s0_f;
  logic [W-1:0]           s0_s;
  logic [W-1:0]           s0_v;

  assign h_cl = (pixel_in.hue > ONE) ? ONE : pixel_in.hue;
  assign s_cl = (pixel_in.saturation > ONE) ? ONE : pixel_in.saturation;
  assign v_cl = (pixel_in.brightness > ONE) ? ONE : pixel_in.brightness;
  assign h6   = ((W + 2)'(h_cl) << 2) + ((W + 2)'(h_cl) << 1);

  always_comb begin
    unique case (h6[W+1:FRAC_BITS])
      3'd1:    sec_next = SEC_1;
      3'd2:    sec_next = SEC_2;
      3'd3:    sec_next = SEC_3;
      3'd4:    sec_next = SEC_4;
      3'd5:    sec_next = SEC_5;
      default: sec_next = SEC_0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_sec <= sec_next;
      s0_f   <= h6[FRAC_BITS-1:0];
      s0_s   <= s_cl;
      s0_v   <= v_cl;
    end
  end

  // Stage 1: S*f, S*(1-f) and p = V*(1-S).
  logic [W-1:0] omf;
  logic [W-1:0] oms;
  logic [W-1:0] s1_sf;
  logic [W-1:0] s1_s1f;
  logic [W-1:0] s1_p;
  logic [W-1:0] s1_v;
  sector_t      s1_sec;

  assign omf = ONE - W'(s0_f);
  assign oms = ONE - s0_s;

  hsv2rgb_fxmul #(.AW(W), .BW(FRAC_BITS), .OW(W), .SHIFT(FRAC_BITS)) u_mul_sf (
    .clk (clk),
    .en  (adv[1]),
    .a   (s0_s),
    .b   (s0_f),
    .y   (s1_sf)
  );

  hsv2rgb_fxmul #(.AW(W), .BW(W), .OW(W), .SHIFT(FRAC_BITS)) u_mul_s1f (
    .clk (clk),
    .en  (adv[1]),
    .a   (s0_s),
    .b   (omf),
    .y   (s1_s1f)
  );

  hsv2rgb_fxmul #(.AW(W), .BW(W), .OW(W), .SHIFT(FRAC_BITS)) u_mul_p (
    .clk (clk),
    .en  (adv[1]),
    .a   (s0_v),
    .b   (oms),
    .y   (s1_p)
  );

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_sec <= s0_sec;
      s1_v   <= s0_v;
    end
  end

  // Stage 2: q = V*(1-S*f) and t = V*(1-S*(1-f)).
  logic [W-1:0] s2_q;
  logic [W-1:0] s2_t;
  logic [W-1:0] s2_p;
  logic [W-1:0] s2_v;
  sector_t      s2_sec;

  hsv2rgb_fxmul #(.AW(W), .BW(W), .OW(W), .SHIFT(FRAC_BITS)) u_mul_q (
    .clk (clk),
    .en  (adv[2]),
    .a   (s1_v),
    .b   (ONE - s1_sf),
    .y   (s2_q)
  );

  hsv2rgb_fxmul #(.AW(W), .BW(W), .OW(W), .SHIFT(FRAC_BITS)) u_mul_t (
    .clk (clk),
    .en  (adv[2]),
    .a   (s1_v),
    .b   (ONE - s1_s1f),
    .y   (s2_t)
  );

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_sec <= s1_sec;
      s2_p   <= s1_p;
      s2_v   <= s1_v;
    end
  end

  // Stage 3: pick the components by sector into the output register.
  logic [W-1:0] r_next;
  logic [W-1:0] g_next;
  logic [W-1:0] b_next;
  logic [W-1:0] red;
  logic [W-1:0] green;
  logic [W-1:0] blue;

  always_comb begin
    unique case (s2_sec)
      SEC_1: begin
        r_next = s2_q; g_next = s2_v; b_next = s2_p;
      end
      SEC_2: begin
        r_next = s2_p; g_next = s2_v; b_next = s2_t;
      end
      SEC_3: begin
        r_next = s2_p; g_next = s2_q; b_next = s2_v;
      end
      SEC_4: begin
        r_next = s2_t; g_next = s2_p; b_next = s2_v;
      end
      SEC_5: begin
        r_next = s2_v; g_next = s2_p; b_next = s2_q;
      end
      default: begin
        r_next = s2_v; g_next = s2_t; b_next = s2_p;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      red   <= r_next;
      green <= g_next;
      blue  <= b_next;
    end
  end

  assign pixel_out.valid     = vld[NUM_STAGES-1];
  assign pixel_out.red_out   = red;
  assign pixel_out.green_out = green;
  assign pixel_out.blue_out  = blue;

endmodule

@@ rtl/hsv2rgb_checker.sv @@
// Port-level checker for the HSV to RGB converter, bound to the top level.
`timescale 1ns / 1ps

module hsv2rgb_checker #(
  parameter int FRAC_BITS = 16
) (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [FRAC_BITS:0] red_out,
  input logic [FRAC_BITS:0] green_out,
  input logic [FRAC_BITS:0] blue_out
);

  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  // A stalled result item holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red_out) && $stable(green_out)
      && $stable(blue_out))
    else $error("stalled output item changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // The pipeline only pushes back when the receiver stalls a full pipeline.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

  // With the receiver ready, an accepted item is checked to reach the output.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("item did not reach the output in time");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> red_out <= ONE && green_out <= ONE && blue_out <= ONE)
    else $error("output component above one");

endmodule

bind hsv_to_rgb_converter_core hsv2rgb_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pixel_in.valid),
  .in_ready  (pixel_in.ready),
  .out_valid (pixel_out.valid),
  .out_ready (pixel_out.ready),
  .red_out   (pixel_out.red_out),
  .green_out (pixel_out.green_out),
  .blue_out  (pixel_out.blue_out)
);
